// ===== src/vpn_pkg.sv =====
// Shared codes, port widths and helpers for the vector path normalizer.
package vpn_pkg;

    // Bus widths (tdata padded to whole bytes).
    localparam int IN_DATA_W  = 232;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 288;
    localparam int OUT_USER_W = 3;

    // Path command opcodes.
    localparam logic [3:0] OP_MOVE     = 4'd0;
    localparam logic [3:0] OP_LINE     = 4'd1;
    localparam logic [3:0] OP_HORIZ    = 4'd2;
    localparam logic [3:0] OP_VERT     = 4'd3;
    localparam logic [3:0] OP_CUBIC    = 4'd4;
    localparam logic [3:0] OP_S_CUBIC  = 4'd5;
    localparam logic [3:0] OP_QUAD     = 4'd6;
    localparam logic [3:0] OP_S_QUAD   = 4'd7;
    localparam logic [3:0] OP_ARC      = 4'd8;
    localparam logic [3:0] OP_CLOSE    = 4'd9;
    localparam logic [3:0] OP_FILL     = 4'd10;

    // Output segment kinds.
    localparam logic [2:0] SEG_START   = 3'd0;
    localparam logic [2:0] SEG_LINE    = 3'd1;
    localparam logic [2:0] SEG_QUAD    = 3'd2;
    localparam logic [2:0] SEG_CUBIC   = 3'd3;
    localparam logic [2:0] SEG_ARC     = 3'd4;
    localparam logic [2:0] SEG_CLOSE   = 3'd5;
    localparam logic [2:0] SEG_FILL    = 3'd6;

    // Magnitude of a signed 32-bit radius, capped to 31 bits.
    function automatic logic [30:0] mag31(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (32'd0 - v) : v;
        return m[31] ? 31'h7FFF_FFFF : m[30:0];
    endfunction

endpackage

// ===== src/vector_path_normalizer.sv =====
// Top level of the vector path normalizer: command register, segment logic, result register.
//
//  Channel   Dir  tdata (low bit up)                               tuser / tlast
//  s_axis    in   ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x,       opcode, is_relative
//                 end_y, arc_angle, big_arc_or_fill, sweep_cw
//  m_axis    out  out_end_x, out_end_y, out_c1_x, out_c1_y,        seg_kind / last_of_item
//                 out_c2_x, out_c2_y, out_rad_x, out_rad_y,
//                 out_angle, out_flags
//
// A command is taken into the command register, turned into its segment by adders and
// multiplexers, and written to the result register: one item per cycle while the
// output does not stall. A drawing command that arrives with no open figure gives two
// results, since the figure start goes out first through the single result register.
// Reset (synchronous, active low) clears the pen, origin, control points and flags.
// A stalled result register holds the command register, which in turn holds off input.
module vector_path_normalizer #(
    parameter int COORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command input.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, arc_angle, big_arc_or_fill,
    // sweep_cw, zero pad
    input  logic [vpn_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // opcode, is_relative
    input  logic [vpn_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    // Segment output.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_end_x, out_end_y, out_c1_x, out_c1_y, out_c2_x, out_c2_y, out_rad_x,
    // out_rad_y, out_angle, out_flags
    output logic [vpn_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // seg_kind
    output logic [vpn_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    // last_of_item
    output logic                            o_m_axis_tlast
);

    localparam int CB = COORD_BITS;

    // Sign-extend or cut a coordinate to the 32-bit output field.
    function automatic logic [31:0] f_to32(input logic [CB-1:0] v);
        logic [CB+63:0] w;
        w = {{64{v[CB-1]}}, v};
        return w[31:0];
    endfunction

    // Command register.
    logic        r_in_valid;
    logic [3:0]  r_op;
    logic        r_rel;
    logic [31:0] r_c1x, r_c1y, r_c2x, r_c2y, r_ex, r_ey, r_ang;
    logic        r_big, r_sweep;

    // Path state.
    logic [CB-1:0] r_pen_x, r_pen_y, r_org_x, r_org_y;
    logic [CB-1:0] r_pcub_x, r_pcub_y, r_pquad_x, r_pquad_y;
    logic          r_fig_open, r_cub_valid, r_quad_valid;
    logic          r_phase;

    // Result register.
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic        r_out_last;
    logic [31:0] r_out_ex, r_out_ey, r_out_c1x, r_out_c1y, r_out_c2x, r_out_c2y, r_out_ang;
    logic [30:0] r_out_rx, r_out_ry;
    logic [1:0]  r_out_flags;

    // Combinational segment values.
    logic [CB-1:0] abs_ex, abs_ey, abs_c1x, abs_c1y, abs_c2x, abs_c2y;
    logic [CB-1:0] refl_cub_x, refl_cub_y, refl_quad_x, refl_quad_y;
    logic [CB-1:0] org_x_eff, org_y_eff;
    logic [CB-1:0] seg_ex, seg_ey, seg_c1x, seg_c1y, seg_c2x, seg_c2y;
    logic [2:0]    seg_kind;
    logic [30:0]   seg_rx, seg_ry;
    logic [31:0]   seg_ang;
    logic [1:0]    seg_flags;

    logic known, needs_fig, need_start, out_free, emit, item_done, in_take;

    logic [2:0]  n_out_kind;
    logic        n_out_last;
    logic [31:0] n_out_ex, n_out_ey, n_out_c1x, n_out_c1y, n_out_c2x, n_out_c2y, n_out_ang;
    logic [30:0] n_out_rx, n_out_ry;
    logic [1:0]  n_out_flags;

    // Absolute points from the command and the pen.
    vpn_coord #(.CB(CB)) u_coord_ex  (.i_base(r_pen_x), .i_val(r_ex),  .i_rel(r_rel),
                                      .o_coord(abs_ex));
    vpn_coord #(.CB(CB)) u_coord_ey  (.i_base(r_pen_y), .i_val(r_ey),  .i_rel(r_rel),
                                      .o_coord(abs_ey));
    vpn_coord #(.CB(CB)) u_coord_c1x (.i_base(r_pen_x), .i_val(r_c1x), .i_rel(r_rel),
                                      .o_coord(abs_c1x));
    vpn_coord #(.CB(CB)) u_coord_c1y (.i_base(r_pen_y), .i_val(r_c1y), .i_rel(r_rel),
                                      .o_coord(abs_c1y));
    vpn_coord #(.CB(CB)) u_coord_c2x (.i_base(r_pen_x), .i_val(r_c2x), .i_rel(r_rel),
                                      .o_coord(abs_c2x));
    vpn_coord #(.CB(CB)) u_coord_c2y (.i_base(r_pen_y), .i_val(r_c2y), .i_rel(r_rel),
                                      .o_coord(abs_c2y));

    // Reflected controls for the smooth curves.
    vpn_reflect #(.CB(CB)) u_refl_cub_x  (.i_pen(r_pen_x), .i_ctrl(r_pcub_x),
                                          .o_refl(refl_cub_x));
    vpn_reflect #(.CB(CB)) u_refl_cub_y  (.i_pen(r_pen_y), .i_ctrl(r_pcub_y),
                                          .o_refl(refl_cub_y));
    vpn_reflect #(.CB(CB)) u_refl_quad_x (.i_pen(r_pen_x), .i_ctrl(r_pquad_x),
                                          .o_refl(refl_quad_x));
    vpn_reflect #(.CB(CB)) u_refl_quad_y (.i_pen(r_pen_y), .i_ctrl(r_pquad_y),
                                          .o_refl(refl_quad_y));

    // A close right after an implicit figure start returns to the origin at zero.
    assign org_x_eff = r_fig_open ? r_org_x : '0;
    assign org_y_eff = r_fig_open ? r_org_y : '0;

    // Flow control: a two-result item emits its figure start in the first phase.
    assign known      = r_op <= vpn_pkg::OP_FILL;
    assign needs_fig  = r_op inside {[vpn_pkg::OP_LINE:vpn_pkg::OP_CLOSE]};
    assign need_start = needs_fig && !r_fig_open && !r_phase;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign emit       = r_in_valid && known && out_free;
    assign item_done  = r_in_valid && (!known || (out_free && !need_start));
    assign in_take    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || item_done;

    // Segment selection by opcode.
    always_comb begin
        seg_kind  = vpn_pkg::SEG_LINE;
        seg_ex    = abs_ex;
        seg_ey    = abs_ey;
        seg_c1x   = '0;
        seg_c1y   = '0;
        seg_c2x   = '0;
        seg_c2y   = '0;
        seg_rx    = '0;
        seg_ry    = '0;
        seg_ang   = '0;
        seg_flags = '0;
        case (r_op)
            vpn_pkg::OP_MOVE: begin
                seg_kind = vpn_pkg::SEG_START;
            end
            vpn_pkg::OP_LINE: begin
                seg_kind = vpn_pkg::SEG_LINE;
            end
            vpn_pkg::OP_HORIZ: begin
                seg_kind = vpn_pkg::SEG_LINE;
                seg_ey   = r_pen_y;
            end
            vpn_pkg::OP_VERT: begin
                seg_kind = vpn_pkg::SEG_LINE;
                seg_ex   = r_pen_x;
            end
            vpn_pkg::OP_CUBIC: begin
                seg_kind = vpn_pkg::SEG_CUBIC;
                seg_c1x  = abs_c1x;
                seg_c1y  = abs_c1y;
                seg_c2x  = abs_c2x;
                seg_c2y  = abs_c2y;
            end
            vpn_pkg::OP_S_CUBIC: begin
                seg_kind = vpn_pkg::SEG_CUBIC;
                seg_c1x  = r_cub_valid ? refl_cub_x : r_pen_x;
                seg_c1y  = r_cub_valid ? refl_cub_y : r_pen_y;
                seg_c2x  = abs_c2x;
                seg_c2y  = abs_c2y;
            end
            vpn_pkg::OP_QUAD: begin
                seg_kind = vpn_pkg::SEG_QUAD;
                seg_c1x  = abs_c1x;
                seg_c1y  = abs_c1y;
            end
            vpn_pkg::OP_S_QUAD: begin
                seg_kind = vpn_pkg::SEG_QUAD;
                seg_c1x  = r_quad_valid ? refl_quad_x : r_pen_x;
                seg_c1y  = r_quad_valid ? refl_quad_y : r_pen_y;
            end
            vpn_pkg::OP_ARC: begin
                seg_kind  = vpn_pkg::SEG_ARC;
                seg_rx    = vpn_pkg::mag31(r_c1x);
                seg_ry    = vpn_pkg::mag31(r_c1y);
                seg_ang   = r_ang;
                seg_flags = {r_sweep, r_big};
            end
            vpn_pkg::OP_CLOSE: begin
                seg_kind = vpn_pkg::SEG_CLOSE;
                seg_ex   = org_x_eff;
                seg_ey   = org_y_eff;
            end
            vpn_pkg::OP_FILL: begin
                seg_kind  = vpn_pkg::SEG_FILL;
                seg_ex    = '0;
                seg_ey    = '0;
                seg_flags = {1'b0, r_big};
            end
            default: begin
                seg_kind = vpn_pkg::SEG_LINE;
            end
        endcase
    end

    // Next result: an implicit figure start at the origin, or the segment itself.
    always_comb begin
        if (need_start) begin
            n_out_kind  = vpn_pkg::SEG_START;
            n_out_last  = 1'b0;
            n_out_ex    = '0;
            n_out_ey    = '0;
            n_out_c1x   = '0;
            n_out_c1y   = '0;
            n_out_c2x   = '0;
            n_out_c2y   = '0;
            n_out_rx    = '0;
            n_out_ry    = '0;
            n_out_ang   = '0;
            n_out_flags = '0;
        end else begin
            n_out_kind  = seg_kind;
            n_out_last  = 1'b1;
            n_out_ex    = f_to32(seg_ex);
            n_out_ey    = f_to32(seg_ey);
            n_out_c1x   = f_to32(seg_c1x);
            n_out_c1y   = f_to32(seg_c1y);
            n_out_c2x   = f_to32(seg_c2x);
            n_out_c2y   = f_to32(seg_c2y);
            n_out_rx    = seg_rx;
            n_out_ry    = seg_ry;
            n_out_ang   = seg_ang;
            n_out_flags = seg_flags;
        end
    end

    // Command register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (item_done) begin
            r_in_valid <= 1'b0;
        end
    end

    // Command register payload.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_s_axis_tuser[3:0];
            r_rel   <= i_s_axis_tuser[4];
            r_c1x   <= i_s_axis_tdata[31:0];
            r_c1y   <= i_s_axis_tdata[63:32];
            r_c2x   <= i_s_axis_tdata[95:64];
            r_c2y   <= i_s_axis_tdata[127:96];
            r_ex    <= i_s_axis_tdata[159:128];
            r_ey    <= i_s_axis_tdata[191:160];
            r_ang   <= i_s_axis_tdata[223:192];
            r_big   <= i_s_axis_tdata[224];
            r_sweep <= i_s_axis_tdata[225];
        end
    end

    // Path state update when an item finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_pcub_x     <= '0;
            r_pcub_y     <= '0;
            r_pquad_x    <= '0;
            r_pquad_y    <= '0;
            r_fig_open   <= 1'b0;
            r_cub_valid  <= 1'b0;
            r_quad_valid <= 1'b0;
            r_phase      <= 1'b0;
        end else begin
            if (emit && need_start) begin
                r_phase <= 1'b1;
            end
            if (item_done) begin
                r_phase <= 1'b0;
            end
            if (item_done && known) begin
                if (r_op == vpn_pkg::OP_MOVE) begin
                    r_pen_x      <= abs_ex;
                    r_pen_y      <= abs_ey;
                    r_org_x      <= abs_ex;
                    r_org_y      <= abs_ey;
                    r_fig_open   <= 1'b1;
                    r_cub_valid  <= 1'b0;
                    r_quad_valid <= 1'b0;
                end else if (r_op == vpn_pkg::OP_FILL) begin
                    r_cub_valid  <= 1'b0;
                    r_quad_valid <= 1'b0;
                end else begin
                    r_pen_x    <= seg_ex;
                    r_pen_y    <= seg_ey;
                    r_org_x    <= org_x_eff;
                    r_org_y    <= org_y_eff;
                    r_fig_open <= 1'b1;
                    r_cub_valid  <= (r_op == vpn_pkg::OP_CUBIC) || (r_op == vpn_pkg::OP_S_CUBIC);
                    r_quad_valid <= (r_op == vpn_pkg::OP_QUAD) || (r_op == vpn_pkg::OP_S_QUAD);
                    if ((r_op == vpn_pkg::OP_CUBIC) || (r_op == vpn_pkg::OP_S_CUBIC)) begin
                        r_pcub_x <= seg_c2x;
                        r_pcub_y <= seg_c2y;
                    end
                    if ((r_op == vpn_pkg::OP_QUAD) || (r_op == vpn_pkg::OP_S_QUAD)) begin
                        r_pquad_x <= seg_c1x;
                        r_pquad_y <= seg_c1y;
                    end
                end
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= n_out_kind;
            r_out_last  <= n_out_last;
            r_out_ex    <= n_out_ex;
            r_out_ey    <= n_out_ey;
            r_out_c1x   <= n_out_c1x;
            r_out_c1y   <= n_out_c1y;
            r_out_c2x   <= n_out_c2x;
            r_out_c2y   <= n_out_c2y;
            r_out_rx    <= n_out_rx;
            r_out_ry    <= n_out_ry;
            r_out_ang   <= n_out_ang;
            r_out_flags <= n_out_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {r_out_flags, r_out_ang, r_out_ry, r_out_rx, r_out_c2y, r_out_c2x,
                              r_out_c1y, r_out_c1x, r_out_ey, r_out_ex};

    // The first phase of a two-result item only exists while its command is held
    // and no figure is open.
    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_in_valid && !r_fig_open))
        else $error("first-phase flag set without a pending command on a closed figure");

    // A figure start that is not the last result is only made for a closed figure.
    a_start_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && need_start) |-> (!r_fig_open && needs_fig))
        else $error("implicit figure start issued while a figure is open");

    // Any finished drawing or move command leaves the figure open.
    a_fig_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_done && known && (r_op != vpn_pkg::OP_FILL)) |=> r_fig_open)
        else $error("figure not open after a drawing command");

    // The smooth-curve history bits are never both set.
    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cub_valid && r_quad_valid))
        else $error("cubic and quadratic control history both marked valid");

endmodule

// ===== src/vpn_coord.sv =====
// Absolute coordinate: optional add of the pen, saturated to the coordinate range.
module vpn_coord #(
    parameter int CB = 32
) (
    input  logic [CB-1:0] i_base,
    input  logic [31:0]   i_val,
    input  logic          i_rel,
    output logic [CB-1:0] o_coord
);

    localparam int SW = ((CB > 32) ? CB : 32) + 1;

    logic [SW-1:0]  base_ext;
    logic [SW-1:0]  val_ext;
    logic [SW-1:0]  sum;
    logic [SW-CB:0] upper;

    // Exact sum in a width that cannot overflow.
    assign base_ext = {{(SW-CB){i_base[CB-1]}}, i_base};
    assign val_ext  = {{(SW-32){i_val[31]}}, i_val};
    assign sum      = i_rel ? (base_ext + val_ext) : val_ext;
    assign upper    = sum[SW-1:CB-1];

    // Clamp to the signed CB-bit range when the upper bits disagree.
    always_comb begin
        if ((&upper) || (~|upper)) begin
            o_coord = sum[CB-1:0];
        end else if (sum[SW-1]) begin
            o_coord = {1'b1, {(CB-1){1'b0}}};
        end else begin
            o_coord = {1'b0, {(CB-1){1'b1}}};
        end
    end

endmodule

// ===== src/vpn_reflect.sv =====
// Reflection of a control point about the pen (2*pen - ctrl), saturated.
module vpn_reflect #(
    parameter int CB = 32
) (
    input  logic [CB-1:0] i_pen,
    input  logic [CB-1:0] i_ctrl,
    output logic [CB-1:0] o_refl
);

    // The doubled pen is held to 64 bits before the subtract.
    localparam int LW = (CB + 1 > 64) ? 64 : CB + 1;

    logic [CB:0]      dbl;
    logic [CB-LW+1:0] dbl_upper;
    logic [LW-1:0]    dbl_sat;
    logic [LW:0]      diff;
    logic [LW-CB+1:0] diff_upper;

    assign dbl       = {i_pen, 1'b0};
    assign dbl_upper = dbl[CB:LW-1];

    always_comb begin
        if ((&dbl_upper) || (~|dbl_upper)) begin
            dbl_sat = dbl[LW-1:0];
        end else if (dbl[CB]) begin
            dbl_sat = {1'b1, {(LW-1){1'b0}}};
        end else begin
            dbl_sat = {1'b0, {(LW-1){1'b1}}};
        end
    end

    assign diff       = {dbl_sat[LW-1], dbl_sat} - {{(LW+1-CB){i_ctrl[CB-1]}}, i_ctrl};
    assign diff_upper = diff[LW:CB-1];

    // Final clamp to the coordinate range.
    always_comb begin
        if ((&diff_upper) || (~|diff_upper)) begin
            o_refl = diff[CB-1:0];
        end else if (diff[LW]) begin
            o_refl = {1'b1, {(CB-1){1'b0}}};
        end else begin
            o_refl = {1'b0, {(CB-1){1'b1}}};
        end
    end

endmodule
